>>> rtl/hojiq_pkg.sv
// ----------------------------------------------------------------------------
// hojiq_pkg
// Shared types and codes for the hazard-ordered job issue queue.
// ----------------------------------------------------------------------------
package hojiq_pkg;

    // Width of the tag fields on the ports
    localparam int TAG_W   = 6;
    // Width of the running limit register
    localparam int LIMIT_W = 4;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    // Result codes
    typedef logic [1:0] t_res;
    localparam t_res RES_ACCEPTED = 2'd0;
    localparam t_res RES_FULL     = 2'd1;
    localparam t_res RES_STARTED  = 2'd2;
    localparam t_res RES_BAD_TAG  = 2'd3;

    // Item kinds
    localparam logic KIND_SUBMIT   = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

endpackage

>>> rtl/hojiq_in_if.sv
// ----------------------------------------------------------------------------
// hojiq_in_if
// Input channel: submit or completion items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hojiq_in_if #(
    parameter int FILE_ID_BITS = 32
);
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [FILE_ID_BITS-1:0]   source_file;
    logic [FILE_ID_BITS-1:0]   target_file;
    logic [hojiq_pkg::TAG_W-1:0] job_tag;

    modport source (output valid, kind, source_file, target_file, job_tag, input ready);
    modport sink   (input valid, kind, source_file, target_file, job_tag, output ready);
endinterface

>>> rtl/hojiq_out_if.sv
// ----------------------------------------------------------------------------
// hojiq_out_if
// Output channel: result items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hojiq_out_if;
    logic                        valid;
    logic                        ready;
    hojiq_pkg::t_res             event_res;
    logic [hojiq_pkg::TAG_W-1:0] tag_out;
    logic                        last;

    modport source (output valid, event_res, tag_out, last, input ready);
    modport sink   (input valid, event_res, tag_out, last, output ready);
endinterface

>>> rtl/hazard_ordered_job_issue_queue.sv
// ----------------------------------------------------------------------------
// hazard_ordered_job_issue_queue
// Arrival-ordered copy job queue that starts jobs free of file hazards.
// ----------------------------------------------------------------------------
// Takes one item at a time and drops ready until its last result has moved
// into the output register. A submit probes tags lowest first until it finds
// a free one, or is rejected at once when the queue is full; a completion
// searches the slots for the running job with its tag and, when it is found,
// moves every later job down one slot. Every item then scans the queue
// oldest first: running positions are skipped and each waiting job is
// compared with the earlier jobs one at a time until one conflicts. The scan
// uses the single conflict comparator and the two read ports of the job
// store. Output backpressure can stall the scan and the end of each item.
// ----------------------------------------------------------------------------
module hazard_ordered_job_issue_queue #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int MAX_RUNNING  = 8,
    parameter int FILE_ID_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hojiq_pkg::LIMIT_W-1:0] i_cfg_wdata,
    hojiq_in_if.sink                      i_job,
    hojiq_out_if.source                   o_res
);
    import hojiq_pkg::*;

    localparam int TW    = $clog2(QUEUE_DEPTH);
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RCW0  = $clog2(MAX_RUNNING + 1);
    localparam int RCW   = (RCW0 > LIMIT_W) ? RCW0 : LIMIT_W;
    localparam int TAGCW = (TW > TAG_W) ? TW : TAG_W;
    localparam int FW    = FILE_ID_BITS;

    localparam logic [CNTW-1:0] DEPTH_C   = CNTW'(QUEUE_DEPTH);
    localparam logic [RCW-1:0]  MAXRUN_C  = RCW'(MAX_RUNNING);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_TAG     = 4'd2;
    localparam logic [3:0] S_FD      = 4'd3;
    localparam logic [3:0] S_FD_C    = 4'd4;
    localparam logic [3:0] S_SH      = 4'd5;
    localparam logic [3:0] S_SH_WR   = 4'd6;
    localparam logic [3:0] S_SC_TOP  = 4'd7;
    localparam logic [3:0] S_SC_WAIT = 4'd8;
    localparam logic [3:0] S_SC_CMP  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    // Control registers
    logic [3:0]             r_state, n_state;
    logic [LIMIT_W-1:0]     r_limit;
    logic [CNTW-1:0]        r_count, n_count;
    logic [RCW-1:0]         r_rc, n_rc;
    logic [QUEUE_DEPTH-1:0] r_run, n_run;
    logic [QUEUE_DEPTH-1:0] r_tags, n_tags;
    logic [CNTW-1:0]        r_i, n_i;
    logic [CNTW-1:0]        r_e, n_e;
    logic [TW-1:0]          r_t, n_t;
    logic                   r_pv, n_pv;
    logic                   r_ov, n_ov;

    // Payload registers
    logic                r_kind;
    logic [FW-1:0]       r_src, r_tgt;
    logic [TAG_W-1:0]    r_jtag;
    t_res                r_pres, n_pres;
    logic [TAGCW-1:0]    r_ptag, n_ptag;
    t_res                r_ores, n_ores;
    logic [TAGCW-1:0]    r_otag, n_otag;
    logic                r_olast, n_olast;

    // Job store
    logic [FW-1:0] m_src [QUEUE_DEPTH];
    logic [FW-1:0] m_tgt [QUEUE_DEPTH];
    logic [TW-1:0] m_tag [QUEUE_DEPTH];
    logic [FW-1:0] r_a_src, r_a_tgt, r_b_src, r_b_tgt;
    logic [TW-1:0] r_a_tag;

    logic          mem_we;
    logic [TW-1:0] mem_waddr;
    logic [FW-1:0] mem_wsrc, mem_wtgt;
    logic [TW-1:0] mem_wtag;

    // Emission and helpers
    logic             out_free, emit_ok, do_emit;
    t_res             em_res;
    logic [TAGCW-1:0] em_tag;
    logic [RCW-1:0]   lim_eff;
    logic             conflict;
    logic [CNTW-1:0]  i_inc;

    assign out_free = !r_ov || o_res.ready;
    assign emit_ok  = !r_pv || out_free;
    assign lim_eff  = (RCW'(r_limit) > MAXRUN_C) ? MAXRUN_C : RCW'(r_limit);
    assign conflict = (r_b_tgt == r_a_tgt) || (r_b_src == r_a_tgt) || (r_b_tgt == r_a_src);
    assign i_inc    = r_i + CNTW'(1);

    assign i_job.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_ov;
    assign o_res.event_res = r_ores;
    assign o_res.tag_out   = r_otag[TAG_W-1:0];
    assign o_res.last      = r_olast;

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rc      = r_rc;
        n_run     = r_run;
        n_tags    = r_tags;
        n_i       = r_i;
        n_e       = r_e;
        n_t       = r_t;
        do_emit   = 1'b0;
        em_res    = RES_ACCEPTED;
        em_tag    = '0;
        mem_we    = 1'b0;
        mem_waddr = r_count[TW-1:0];
        mem_wsrc  = r_src;
        mem_wtgt  = r_tgt;
        mem_wtag  = r_t;
        case (r_state)
            S_IDLE: begin
                if (i_job.valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_i = '0;
                n_t = '0;
                if (r_kind == KIND_COMPLETE) begin
                    n_state = S_FD;
                end else if (r_count >= DEPTH_C) begin
                    do_emit = 1'b1;
                    em_res  = RES_FULL;
                    n_state = S_SC_TOP;
                end else begin
                    n_state = S_TAG;
                end
            end
            // Probe tags lowest first; a free one always exists here
            S_TAG: begin
                if (!r_tags[r_t]) begin
                    mem_we        = 1'b1;
                    n_tags[r_t]   = 1'b1;
                    n_run[r_count[TW-1:0]] = 1'b0;
                    n_count       = r_count + CNTW'(1);
                    do_emit       = 1'b1;
                    em_res        = RES_ACCEPTED;
                    em_tag        = TAGCW'(r_t);
                    n_state       = S_SC_TOP;
                end else begin
                    n_t = r_t + TW'(1);
                end
            end
            // Search for the running job with the completed tag
            S_FD: begin
                if (r_i >= r_count) begin
                    do_emit = 1'b1;
                    em_res  = RES_BAD_TAG;
                    em_tag  = TAGCW'(r_jtag);
                    n_i     = '0;
                    n_state = S_SC_TOP;
                end else begin
                    n_state = S_FD_C;
                end
            end
            S_FD_C: begin
                if (r_run[r_i[TW-1:0]] && (TAGCW'(r_a_tag) == TAGCW'(r_jtag))) begin
                    for (int j = 0; j < QUEUE_DEPTH; j++) begin
                        if (j >= int'(r_i)) begin
                            n_run[j] = (j < QUEUE_DEPTH - 1) ? r_run[j+1] : 1'b0;
                        end
                    end
                    n_tags[r_a_tag] = 1'b0;
                    n_rc    = (r_rc != '0) ? r_rc - RCW'(1) : r_rc;
                    n_i     = i_inc;
                    n_state = S_SH;
                end else begin
                    n_i     = i_inc;
                    n_state = S_FD;
                end
            end
            // Move later jobs down one place to close the gap
            S_SH: begin
                if (r_i >= r_count) begin
                    n_count = r_count - CNTW'(1);
                    n_i     = '0;
                    n_state = S_SC_TOP;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = TW'(r_i - CNTW'(1));
                mem_wsrc  = r_a_src;
                mem_wtgt  = r_a_tgt;
                mem_wtag  = r_a_tag;
                n_i       = i_inc;
                n_state   = S_SH;
            end
            // Oldest-first scan for jobs that may start
            S_SC_TOP: begin
                if ((r_rc >= lim_eff) || (r_i >= r_count)) begin
                    n_state = S_DONE;
                end else if (r_run[r_i[TW-1:0]]) begin
                    n_i = i_inc;
                end else begin
                    n_e     = '0;
                    n_state = S_SC_WAIT;
                end
            end
            S_SC_WAIT: begin
                n_state = S_SC_CMP;
            end
            S_SC_CMP: begin
                if (r_e == r_i) begin
                    if (emit_ok) begin
                        do_emit = 1'b1;
                        em_res  = RES_STARTED;
                        em_tag  = TAGCW'(r_a_tag);
                        n_run[r_i[TW-1:0]] = 1'b1;
                        n_rc    = r_rc + RCW'(1);
                        n_i     = i_inc;
                        n_state = S_SC_TOP;
                    end
                end else if (conflict) begin
                    n_i     = i_inc;
                    n_state = S_SC_TOP;
                end else begin
                    n_e     = r_e + CNTW'(1);
                    n_state = S_SC_WAIT;
                end
            end
            S_DONE: begin
                if (!r_pv || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Pending result and output register: the last result is known at scan end
    always_comb begin
        n_pv    = r_pv;
        n_pres  = r_pres;
        n_ptag  = r_ptag;
        n_ov    = r_ov && !o_res.ready;
        n_ores  = r_ores;
        n_otag  = r_otag;
        n_olast = r_olast;
        if (do_emit) begin
            if (r_pv) begin
                n_ov    = 1'b1;
                n_ores  = r_pres;
                n_otag  = r_ptag;
                n_olast = 1'b0;
            end
            n_pv   = 1'b1;
            n_pres = em_res;
            n_ptag = em_tag;
        end else if ((r_state == S_DONE) && r_pv && out_free) begin
            n_ov    = 1'b1;
            n_ores  = r_pres;
            n_otag  = r_ptag;
            n_olast = 1'b1;
            n_pv    = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RESET;
            r_count <= '0;
            r_rc    <= '0;
            r_run   <= '0;
            r_tags  <= '0;
            r_i     <= '0;
            r_e     <= '0;
            r_t     <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_rc    <= n_rc;
            r_run   <= n_run;
            r_tags  <= n_tags;
            r_i     <= n_i;
            r_e     <= n_e;
            r_t     <= n_t;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_job.valid && i_job.ready) begin
            r_kind <= i_job.kind;
            r_src  <= i_job.source_file;
            r_tgt  <= i_job.target_file;
            r_jtag <= i_job.job_tag;
        end
        r_pres  <= n_pres;
        r_ptag  <= n_ptag;
        r_ores  <= n_ores;
        r_otag  <= n_otag;
        r_olast <= n_olast;
    end

    // Job store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_src[mem_waddr] <= mem_wsrc;
            m_tgt[mem_waddr] <= mem_wtgt;
            m_tag[mem_waddr] <= mem_wtag;
        end
        r_a_src <= m_src[r_i[TW-1:0]];
        r_a_tgt <= m_tgt[r_i[TW-1:0]];
        r_a_tag <= m_tag[r_i[TW-1:0]];
        r_b_src <= m_src[r_e[TW-1:0]];
        r_b_tgt <= m_tgt[r_e[TW-1:0]];
    end

    // Checks
    a_rc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rc <= MAXRUN_C)
        else $error("running count above the maximum");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_run) == int'(r_rc)))
        else $error("running bits disagree with running count");

    a_tag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_tags) == int'(r_count)))
        else $error("tags in use disagree with queue fill");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("pending result left over at idle");

endmodule

>>> dv/hazard_ordered_job_issue_queue_tb.sv
// ----------------------------------------------------------------------------
// hazard_ordered_job_issue_queue_tb
// Self-checking bench for the job issue queue. A behavioral copy of the
// queue predicts the accept, reject, bad-tag and start results of every
// item; a checker compares each result in order. Directed tests cover
// field extremes, each hazard type, a full queue and the limit corners,
// then a random phase mixes submits, completions and bad tags.
// ----------------------------------------------------------------------------
module hazard_ordered_job_issue_queue_tb;
    import hojiq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int RUN_CAP     = 8;
    localparam int SETTLE_CYC  = 9000;
    localparam int STALL_LIMIT = 60000;
    localparam int HOLD_CYC    = 400;

    typedef struct {
        t_res       res;
        logic [5:0] tag;
        logic       last;
    } t_job_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata = '0;

    hojiq_in_if #(.FILE_ID_BITS(32)) job_if();
    hojiq_out_if res_if();

    hazard_ordered_job_issue_queue i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_job      (job_if),
        .o_res      (res_if)
    );

    always #1 i_clk = ~i_clk;

    // Queue state mirror
    logic [31:0] q_src [DEPTH];
    logic [31:0] q_dst [DEPTH];
    logic [5:0]  q_tag [DEPTH];
    logic        q_run [DEPTH];
    logic        tag_used [DEPTH];
    int          q_count;
    int          run_count;
    int          run_limit = LIMIT_RESET;

    t_job_result pending_results[$];
    int errors;
    int items_sent;
    int results_seen;
    int starts_seen;
    int rejects_seen;
    int bad_tags_seen;
    int idle_cnt;
    bit no_idle;
    bit hold_req;
    int hold_left;

    initial begin
        job_if.valid       = 1'b0;
        job_if.kind        = KIND_SUBMIT;
        job_if.source_file = '0;
        job_if.target_file = '0;
        job_if.job_tag     = '0;
        res_if.ready       = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            q_run[k]    = 1'b0;
            tag_used[k] = 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // Work out the results of one accepted item and advance the mirror
    function automatic void predict_job_results(input logic kind, input logic [31:0] src,
                                                input logic [31:0] dst, input logic [5:0] tag);
        int n0;
        int pos;
        int lim;
        int t;
        bit blocked;
        n0 = pending_results.size();
        pos = -1;
        if (kind == KIND_SUBMIT) begin
            t = 0;
            while (t < DEPTH && tag_used[t]) t++;
            if (q_count >= DEPTH || t >= DEPTH) begin
                pending_results.push_back('{RES_FULL, 6'd0, 1'b0});
            end else begin
                tag_used[t]    = 1'b1;
                q_src[q_count] = src;
                q_dst[q_count] = dst;
                q_tag[q_count] = t[5:0];
                q_run[q_count] = 1'b0;
                q_count++;
                pending_results.push_back('{RES_ACCEPTED, t[5:0], 1'b0});
            end
        end else begin
            for (int i = 0; i < q_count; i++) begin
                if (pos < 0 && q_run[i] && q_tag[i] == tag) pos = i;
            end
            if (pos >= 0) begin
                run_count--;
                tag_used[tag] = 1'b0;
                for (int k = pos; k + 1 < q_count; k++) begin
                    q_src[k] = q_src[k+1];
                    q_dst[k] = q_dst[k+1];
                    q_tag[k] = q_tag[k+1];
                    q_run[k] = q_run[k+1];
                end
                q_count--;
                q_run[q_count] = 1'b0;
            end else begin
                pending_results.push_back('{RES_BAD_TAG, tag, 1'b0});
            end
        end
        // Scan oldest first; a job starts when no earlier job shares a file hazard
        lim = (run_limit > RUN_CAP) ? RUN_CAP : run_limit;
        for (int i = 0; i < q_count; i++) begin
            if (run_count >= lim) break;
            if (q_run[i]) continue;
            blocked = 1'b0;
            for (int e = 0; e < i; e++) begin
                if (q_dst[e] == q_dst[i] || q_src[e] == q_dst[i] || q_dst[e] == q_src[i])
                    blocked = 1'b1;
            end
            if (blocked) continue;
            q_run[i] = 1'b1;
            run_count++;
            pending_results.push_back('{RES_STARTED, q_tag[i], 1'b0});
        end
        if (pending_results.size() > n0)
            pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    // Predict on each accepted item, then check each accepted result
    always @(posedge i_clk) begin
        t_job_result want;
        if (i_rst_n && job_if.valid && job_if.ready) begin
            predict_job_results(job_if.kind, job_if.source_file, job_if.target_file,
                                job_if.job_tag);
            items_sent++;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result res=%0d tag=%0d",
                                          res_if.event_res, res_if.tag_out));
            end else begin
                want = pending_results.pop_front();
                if (want.res == RES_STARTED) starts_seen++;
                if (want.res == RES_FULL) rejects_seen++;
                if (want.res == RES_BAD_TAG) bad_tags_seen++;
                if (res_if.event_res !== want.res)
                    report_mismatch($sformatf("event_res %0d, want %0d",
                                              res_if.event_res, want.res));
                if (res_if.tag_out !== want.tag)
                    report_mismatch($sformatf("tag_out %0d, want %0d",
                                              res_if.tag_out, want.tag));
                if (res_if.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b tag %0d",
                                              res_if.last, want.last, want.tag));
            end
        end
    end

    // Result receiver: random stalls, plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYC;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= no_idle || ($urandom_range(99) >= 12);
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((job_if.valid && job_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_LIMIT) begin
            $display("[hazard_ordered_job_issue_queue] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [31:0] src,
                             input logic [31:0] dst, input logic [5:0] tag);
        if (!no_idle && $urandom_range(99) < 12) begin
            job_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        job_if.valid       <= 1'b1;
        job_if.kind        <= kind;
        job_if.source_file <= src;
        job_if.target_file <= dst;
        job_if.job_tag     <= tag;
        do @(posedge i_clk); while (!job_if.ready);
    endtask

    task automatic submit_job(input logic [31:0] src, input logic [31:0] dst);
        send_item(KIND_SUBMIT, src, dst, 6'($urandom()));
    endtask

    task automatic complete_job(input logic [5:0] tag);
        send_item(KIND_COMPLETE, $urandom(), $urandom(), tag);
    endtask

    // Hold the sender until every result is back
    task automatic wait_results_done();
        job_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Idle the block fully, then write the running limit
    task automatic set_running_limit(input int value);
        wait_results_done();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[LIMIT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        run_limit = value;
    endtask

    function automatic int pick_running_tag();
        int tags[$];
        for (int i = 0; i < q_count; i++)
            if (q_run[i]) tags.push_back(q_tag[i]);
        if (tags.size() == 0) return -1;
        return tags[$urandom_range(tags.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_file();
        if ($urandom_range(99) < 80) return $urandom_range(7);
        return $urandom();
    endfunction

    // Complete running jobs until the queue is empty
    task automatic drain_queue();
        int t;
        while (q_count > 0) begin
            wait_results_done();
            t = pick_running_tag();
            if (t < 0) complete_job(6'd63);
            else complete_job(t[5:0]);
        end
        wait_results_done();
    endtask

    // Field extremes, each hazard type and bad completion tags
    task automatic test_directed();
        submit_job(32'h0000_0000, 32'hFFFF_FFFF);
        submit_job(32'h1111_1111, 32'hFFFF_FFFF);  // same target: waits
        submit_job(32'hFFFF_FFFF, 32'h2222_2222);  // reads the first target: waits
        submit_job(32'h3333_3333, 32'h0000_0000);  // writes the first source: waits
        submit_job(32'h4444_4444, 32'h5555_5555);  // independent: starts
        wait_results_done();
        complete_job(6'd1);                        // still waiting
        complete_job(6'd63);                       // free tag
        complete_job(6'd0);
        complete_job(6'd0);                        // already gone
        complete_job(6'd4);
        drain_queue();
    endtask

    // Running limit of one serializes independent jobs
    task automatic test_limit_one();
        set_running_limit(1);
        for (int i = 0; i < 6; i++) submit_job(32'h100 + i, 32'h200 + i);
        drain_queue();
    endtask

    // Limit zero holds every job, fill to reject, then release with an oversized limit
    task automatic test_full_queue();
        set_running_limit(0);
        for (int i = 0; i < DEPTH; i++) submit_job(pick_file(), $urandom());
        submit_job(32'hA, 32'hB);
        submit_job(32'hC, 32'hD);
        set_running_limit(15);
        complete_job(6'd63);                       // waiting job: bad tag, triggers a scan
        drain_queue();
        set_running_limit(8);
    endtask

    // Long output hold while the sender keeps offering items
    task automatic test_output_hold();
        no_idle = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) submit_job(pick_file(), pick_file());
        no_idle = 1'b0;
        drain_queue();
    endtask

    // Random mix of submits, completions and bad tags over several limits
    task automatic test_random(input int count);
        int t;
        int r;
        for (int i = 0; i < count; i++) begin
            no_idle = (i % 100) >= 70 && (i % 100) < 90;
            r = $urandom_range(99);
            t = pick_running_tag();
            if (r < 8) complete_job(6'($urandom_range(63)));
            else if (t >= 0 && (r < 50 || q_count >= 20)) complete_job(t[5:0]);
            else submit_job(pick_file(), pick_file());
            if (i % 90 == 89) begin
                drain_queue();
                set_running_limit($urandom_range(1, 8));
            end
        end
        no_idle = 1'b0;
        drain_queue();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limit_one();
        test_full_queue();
        test_output_hold();
        test_random(215);
        wait_results_done();
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("Covered %0d items, %0d results: %0d starts, %0d rejects, %0d bad tags,",
                 items_sent, results_seen, starts_seen, rejects_seen, bad_tags_seen);
        $display("limits 0, 1, 8, 15 and random, a full queue and a long output hold.");
        if (errors == 0 && pending_results.size() == 0)
            $display("[hazard_ordered_job_issue_queue] OK");
        else
            $display("[hazard_ordered_job_issue_queue] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hojiq_pkg.sv
rtl/hojiq_in_if.sv
rtl/hojiq_out_if.sv
rtl/hazard_ordered_job_issue_queue.sv
dv/hazard_ordered_job_issue_queue_tb.sv
